>>> rtl/grayscale_oled_region_writer_core_assert.svh
// Assertion macros used by the back end of the grayscale OLED region writer.
`ifndef GRAYSCALE_OLED_REGION_WRITER_CORE_ASSERT_SVH
`define GRAYSCALE_OLED_REGION_WRITER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ORW_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ORW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

>>> rtl/orw_pkg.sv
// Types, constants and the power-up table of the grayscale OLED region writer.
package orw_pkg;

    localparam int PANEL_COLUMNS_DEF = 256;
    localparam int PANEL_ROWS_DEF    = 128;
    localparam int QUEUE_DEPTH_DEF   = 4;

    localparam int BYTES_LEFT_W = 15;
    localparam int INIT_LEN     = 34;
    localparam int REGION_LEN   = 7;
    localparam int STEP_W       = $clog2(INIT_LEN);
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 8;

    localparam logic [1:0] KIND_REGION = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_INIT   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_OFFSET      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OSCILLATOR_SETTING = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MUX_RATIO          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_CURRENT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MASTER_CURRENT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PRECHARGE_VOLTAGE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PRECHARGE_PERIOD   = 3'd6;

    localparam logic [7:0] CMD_SET_ROW    = 8'h75;
    localparam logic [7:0] CMD_SET_COLUMN = 8'h15;
    localparam logic [7:0] CMD_WRITE_RAM  = 8'h5c;

    localparam int STEP_OSCILLATOR = 4;
    localparam int STEP_MUX        = 6;
    localparam int STEP_SEGMENT    = 20;
    localparam int STEP_MASTER     = 22;
    localparam int STEP_PRE_VOLT   = 27;
    localparam int STEP_PRE_PERIOD = 29;

    localparam logic [7:0] INIT_BYTES [INIT_LEN] = '{
        8'hfd, 8'h12, 8'hae, 8'hb3, 8'h91, 8'hca, 8'h3f, 8'ha2, 8'h00, 8'ha1, 8'h00,
        8'ha0, 8'h14, 8'h11, 8'hab, 8'h01, 8'hb4, 8'ha0, 8'hfd, 8'hc1, 8'hff, 8'hc7,
        8'h0f, 8'hb9, 8'hb1, 8'he2, 8'hbb, 8'h1f, 8'hb6, 8'h08, 8'hbe, 8'h07, 8'ha7,
        8'haf
    };
    localparam bit INIT_DC [INIT_LEN] = '{
        1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
        1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0,
        1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
        1'b0
    };

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] x_first;
        logic [7:0] x_last;
        logic [6:0] y_first;
        logic [6:0] y_last;
        logic [5:0] green;
    } t_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       run_last;
        logic       region_done;
    } t_result;

    typedef struct packed {
        logic [6:0] column_offset;
        logic [7:0] oscillator_setting;
        logic [6:0] mux_ratio;
        logic [7:0] segment_current;
        logic [3:0] master_current;
        logic [4:0] precharge_voltage;
        logic [3:0] precharge_period;
    } t_cfg;

    typedef enum logic [1:0] {
        JOB_INIT,
        JOB_REGION,
        JOB_PIXEL
    } t_job_op;

    typedef struct packed {
        t_job_op    op;
        logic [7:0] arg0;
        logic [7:0] arg1;
        logic [7:0] arg2;
        logic [7:0] arg3;
        logic       done;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_queue_head;

    // Returns the data/command flag and the byte of one power-up step.
    function automatic logic [8:0] init_entry(input logic [STEP_W-1:0] step, input t_cfg cfg);
        logic [7:0] b;
        logic       dc;
        b  = 8'h00;
        dc = 1'b0;
        if (int'(step) < INIT_LEN) begin
            b  = INIT_BYTES[step];
            dc = INIT_DC[step];
        end
        case (int'(step))
            STEP_OSCILLATOR: b = cfg.oscillator_setting;
            STEP_MUX:        b = {1'b0, cfg.mux_ratio};
            STEP_SEGMENT:    b = cfg.segment_current;
            STEP_MASTER:     b = {4'h0, cfg.master_current};
            STEP_PRE_VOLT:   b = {3'h0, cfg.precharge_voltage};
            STEP_PRE_PERIOD: b = {4'h0, cfg.precharge_period};
            default:         b = b;
        endcase
        return {dc, b};
    endfunction

endpackage

>>> rtl/orw_stream_if.sv
// Valid/ready stream channel carrying one payload per transfer.
interface orw_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/grayscale_oled_region_writer_core.sv
// Top level of the grayscale OLED region writer: configuration registers and the job pipeline.
//
// Usage: items enter on i_item (kind, region bounds, green value); controller bytes leave on
// o_result, each with its data/command flag, a flag on the last byte of its item and a flag
// on the final pixel byte of the region. Both are valid/ready channels; a transfer happens
// when valid and ready are high at a rising edge. Registers are written through i_cfg_we,
// i_cfg_index and i_cfg_data; the user must do so only while the block is idle, as the block
// does not enforce it. Unknown indexes are ignored. An item is taken every cycle while the
// job queue has room. The job it causes is written into the queue, and its bytes are
// registered in the output register. The output side delivers one byte per cycle while the
// receiver is ready; an init item gives 34 bytes, a region item 7 and a pixel pair 1, so
// pixel streams run at one item per cycle. Reset clears the queue, the output valid flag
// and the region byte counter, and loads the register defaults. When the receiver stalls,
// the output byte holds, the queue fills and i_item.ready falls once it is full.
module grayscale_oled_region_writer_core #(
    parameter int PANEL_COLUMNS = orw_pkg::PANEL_COLUMNS_DEF,
    parameter int PANEL_ROWS    = orw_pkg::PANEL_ROWS_DEF,
    parameter int QUEUE_DEPTH   = orw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    orw_stream_if.sink                        i_item,
    orw_stream_if.source                      o_result,
    input  logic                              i_cfg_we,
    input  logic [orw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [orw_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import orw_pkg::*;

    t_cfg        r_cfg;
    t_cfg        n_cfg;
    logic        push;
    t_job        push_job;
    logic        full;
    logic        pop;
    t_queue_head head;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_COLUMN_OFFSET:      n_cfg.column_offset      = i_cfg_data[6:0];
                CFG_OSCILLATOR_SETTING: n_cfg.oscillator_setting = i_cfg_data;
                CFG_MUX_RATIO:          n_cfg.mux_ratio          = i_cfg_data[6:0];
                CFG_SEGMENT_CURRENT:    n_cfg.segment_current    = i_cfg_data;
                CFG_MASTER_CURRENT:     n_cfg.master_current     = i_cfg_data[3:0];
                CFG_PRECHARGE_VOLTAGE:  n_cfg.precharge_voltage  = i_cfg_data[4:0];
                CFG_PRECHARGE_PERIOD:   n_cfg.precharge_period   = i_cfg_data[3:0];
                default:                n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.column_offset      <= 7'd28;
            r_cfg.oscillator_setting <= 8'd145;
            r_cfg.mux_ratio          <= 7'd63;
            r_cfg.segment_current    <= 8'd255;
            r_cfg.master_current     <= 4'd15;
            r_cfg.precharge_voltage  <= 5'd31;
            r_cfg.precharge_period   <= 4'd8;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    orw_front #(
        .PANEL_COLUMNS (PANEL_COLUMNS),
        .PANEL_ROWS    (PANEL_ROWS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg      (r_cfg),
        .i_full     (full),
        .o_push     (push),
        .o_push_job (push_job)
    );

    orw_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .o_full     (full),
        .i_pop      (pop),
        .o_head     (head)
    );

    orw_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_head   (head),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule

>>> rtl/orw_queue.sv
// Short job queue between the classifying front end and the byte sequencer.
module orw_queue #(
    parameter int QUEUE_DEPTH = orw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  orw_pkg::t_job      i_push_job,
    output logic               o_full,
    input  logic               i_pop,
    output orw_pkg::t_queue_head o_head
);
    import orw_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full       = (r_count == CNT_FULL);
    assign o_head.valid = (r_count != '0);
    assign o_head.job   = r_mem[r_rd_ptr];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head.valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

>>> rtl/orw_front.sv
// Front end: accepts items, checks regions, tracks the pixel budget and packs nibbles.
module orw_front #(
    parameter int PANEL_COLUMNS = orw_pkg::PANEL_COLUMNS_DEF,
    parameter int PANEL_ROWS    = orw_pkg::PANEL_ROWS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    orw_stream_if.sink    i_item,
    input  orw_pkg::t_cfg i_cfg,
    input  logic          i_full,
    output logic          o_push,
    output orw_pkg::t_job o_push_job
);
    import orw_pkg::*;

    logic [BYTES_LEFT_W-1:0] r_bytes_left;
    logic                    r_waiting;
    logic [3:0]              r_held;
    logic [BYTES_LEFT_W-1:0] n_bytes_left;
    logic                    n_waiting;
    logic [3:0]              n_held;

    t_item       item;
    logic        accept;
    logic [7:0]  x1;
    logic [7:0]  x2;
    logic [8:0]  span_x;
    logic [7:0]  span_y;
    logic [16:0] area;
    logic        region_ok;
    logic [3:0]  gray;

    assign item          = i_item.payload;
    assign i_item.ready  = !i_full;
    assign accept        = i_item.valid && !i_full;

    assign x1        = item.x_first & 8'hfc;
    assign x2        = item.x_last | 8'h03;
    assign span_x    = {1'b0, x2} - {1'b0, x1} + 9'd1;
    assign span_y    = {1'b0, item.y_last} - {1'b0, item.y_first} + 8'd1;
    assign area      = span_x * span_y;
    assign gray      = item.green[5:2];
    assign region_ok = (x2 >= x1) && (item.y_last >= item.y_first)
                    && (32'(x2) < PANEL_COLUMNS) && (32'(item.y_last) < PANEL_ROWS);

    always_comb begin
        n_bytes_left    = r_bytes_left;
        n_waiting       = r_waiting;
        n_held          = r_held;
        o_push          = 1'b0;
        o_push_job.op   = JOB_PIXEL;
        o_push_job.arg0 = {r_held, gray};
        o_push_job.arg1 = {1'b0, item.y_last};
        o_push_job.arg2 = 8'({1'b0, i_cfg.column_offset} + {2'b00, x1[7:2]});
        o_push_job.arg3 = 8'({1'b0, i_cfg.column_offset} + {2'b00, x2[7:2]});
        o_push_job.done = (r_bytes_left == BYTES_LEFT_W'(1));
        if (accept) begin
            case (item.kind)
                KIND_INIT: begin
                    o_push        = 1'b1;
                    o_push_job.op = JOB_INIT;
                    n_bytes_left  = '0;
                    n_waiting     = 1'b0;
                    n_held        = 4'h0;
                end
                KIND_REGION: begin
                    if (region_ok) begin
                        o_push          = 1'b1;
                        o_push_job.op   = JOB_REGION;
                        o_push_job.arg0 = {1'b0, item.y_first};
                        n_bytes_left    = area[BYTES_LEFT_W:1];
                        n_waiting       = 1'b0;
                        n_held          = 4'h0;
                    end
                end
                KIND_PIXEL: begin
                    if (r_bytes_left != '0) begin
                        if (!r_waiting) begin
                            n_held    = gray;
                            n_waiting = 1'b1;
                        end else begin
                            o_push       = 1'b1;
                            n_waiting    = 1'b0;
                            n_bytes_left = r_bytes_left - 1'b1;
                        end
                    end
                end
                default: begin
                    n_bytes_left = r_bytes_left;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= '0;
            r_waiting    <= 1'b0;
            r_held       <= 4'h0;
        end else begin
            r_bytes_left <= n_bytes_left;
            r_waiting    <= n_waiting;
            r_held       <= n_held;
        end
    end

endmodule

>>> rtl/orw_back.sv
// Back end: walks each queued job byte by byte into the output register.
`include "grayscale_oled_region_writer_core_assert.svh"

module orw_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  orw_pkg::t_cfg        i_cfg,
    input  orw_pkg::t_queue_head i_head,
    output logic                 o_pop,
    orw_stream_if.source         o_result
);
    import orw_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic              r_out_valid;
    logic              n_out_valid;
    t_result           r_out;
    t_result           n_out;

    logic              load;
    logic [STEP_W-1:0] last_step;
    logic [7:0]        cur_byte;
    logic              cur_dc;
    logic              cur_done;
    logic [8:0]        init_word;

    assign init_word = init_entry(r_step, i_cfg);
    assign load      = i_head.valid && (!r_out_valid || o_result.ready);
    assign o_pop     = load && (r_step == last_step);

    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

    always_comb begin
        cur_byte  = 8'h00;
        cur_dc    = 1'b0;
        cur_done  = 1'b0;
        last_step = '0;
        unique case (i_head.job.op)
            JOB_INIT: begin
                cur_dc    = init_word[8];
                cur_byte  = init_word[7:0];
                last_step = STEP_W'(INIT_LEN - 1);
            end
            JOB_REGION: begin
                last_step = STEP_W'(REGION_LEN - 1);
                unique case (r_step)
                    STEP_W'(0): cur_byte = CMD_SET_ROW;
                    STEP_W'(1): begin
                        cur_byte = i_head.job.arg0;
                        cur_dc   = 1'b1;
                    end
                    STEP_W'(2): begin
                        cur_byte = i_head.job.arg1;
                        cur_dc   = 1'b1;
                    end
                    STEP_W'(3): cur_byte = CMD_SET_COLUMN;
                    STEP_W'(4): begin
                        cur_byte = i_head.job.arg2;
                        cur_dc   = 1'b1;
                    end
                    STEP_W'(5): begin
                        cur_byte = i_head.job.arg3;
                        cur_dc   = 1'b1;
                    end
                    default: cur_byte = CMD_WRITE_RAM;
                endcase
            end
            JOB_PIXEL: begin
                cur_byte = i_head.job.arg0;
                cur_dc   = 1'b1;
                cur_done = i_head.job.done;
            end
            default: begin
                last_step = '0;
            end
        endcase
    end

    always_comb begin
        n_step      = r_step;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (load) begin
            n_out_valid       = 1'b1;
            n_out.out_byte    = cur_byte;
            n_out.is_data     = cur_dc;
            n_out.run_last    = (r_step == last_step);
            n_out.region_done = cur_done;
            n_step            = (r_step == last_step) ? '0 : r_step + 1'b1;
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    `ORW_ASSERT_IMPLY(a_step_needs_job, i_clk, i_rst_n, r_step != '0, i_head.valid)
    `ORW_ASSERT_IMPLY(a_done_is_final_data, i_clk, i_rst_n, r_out_valid && r_out.region_done, r_out.is_data && r_out.run_last)
    `ORW_ASSERT_NEXT(a_pop_gives_run_last, i_clk, i_rst_n, o_pop, r_out_valid && r_out.run_last && (r_step == '0))

endmodule

>>> tb/sv/grayscale_oled_region_writer_core_checker.sv
// Checker that predicts the controller byte stream from observed transfers and compares it.
`timescale 1ns / 100ps
module grayscale_oled_region_writer_core_checker
    import orw_pkg::*;
#(
    parameter int PANEL_COLUMNS = PANEL_COLUMNS_DEF,
    parameter int PANEL_ROWS    = PANEL_ROWS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_item_valid,
    input  logic                  i_item_ready,
    input  t_item                 i_item_payload,
    input  logic                  i_result_valid,
    input  logic                  i_result_ready,
    input  t_result               i_result_payload,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_outstanding
);

    t_cfg                    panel_cfg;
    logic [3:0]              held_nibble;
    logic                    nibble_waiting;
    logic [BYTES_LEFT_W-1:0] bytes_left;
    t_result                 expected_bytes[$];
    int                      mismatches;

    task automatic push_byte(input logic [7:0] b, input logic dc, input logic last,
                             input logic done);
        t_result r;
        r.out_byte    = b;
        r.is_data     = dc;
        r.run_last    = last;
        r.region_done = done;
        expected_bytes.push_back(r);
    endtask

    task automatic predict_bytes(input t_item it);
        logic [7:0] b;
        logic [7:0] x1;
        logic [7:0] x2;
        logic [7:0] col;
        logic [3:0] gray;
        int         step;
        case (it.kind)
            KIND_INIT: begin
                for (step = 0; step < INIT_LEN; step++) begin
                    case (step)
                        STEP_OSCILLATOR: b = panel_cfg.oscillator_setting;
                        STEP_MUX:        b = {1'b0, panel_cfg.mux_ratio};
                        STEP_SEGMENT:    b = panel_cfg.segment_current;
                        STEP_MASTER:     b = {4'h0, panel_cfg.master_current};
                        STEP_PRE_VOLT:   b = {3'h0, panel_cfg.precharge_voltage};
                        STEP_PRE_PERIOD: b = {4'h0, panel_cfg.precharge_period};
                        default:         b = INIT_BYTES[step];
                    endcase
                    push_byte(b, INIT_DC[step], step == INIT_LEN - 1, 1'b0);
                end
                bytes_left     = '0;
                nibble_waiting = 1'b0;
                held_nibble    = '0;
            end
            KIND_REGION: begin
                x1 = it.x_first & 8'hfc;
                x2 = it.x_last | 8'h03;
                if (x2 >= x1 && it.y_last >= it.y_first && int'(x2) < PANEL_COLUMNS
                        && int'(it.y_last) < PANEL_ROWS) begin
                    push_byte(CMD_SET_ROW, 1'b0, 1'b0, 1'b0);
                    push_byte({1'b0, it.y_first}, 1'b1, 1'b0, 1'b0);
                    push_byte({1'b0, it.y_last}, 1'b1, 1'b0, 1'b0);
                    push_byte(CMD_SET_COLUMN, 1'b0, 1'b0, 1'b0);
                    col = {1'b0, panel_cfg.column_offset} + {2'b00, x1[7:2]};
                    push_byte(col, 1'b1, 1'b0, 1'b0);
                    col = {1'b0, panel_cfg.column_offset} + {2'b00, x2[7:2]};
                    push_byte(col, 1'b1, 1'b0, 1'b0);
                    push_byte(CMD_WRITE_RAM, 1'b0, 1'b1, 1'b0);
                    bytes_left = BYTES_LEFT_W'(((int'(x2) - int'(x1) + 1)
                        * (int'(it.y_last) - int'(it.y_first) + 1)) >> 1);
                    nibble_waiting = 1'b0;
                    held_nibble    = '0;
                end
            end
            KIND_PIXEL: begin
                gray = it.green[5:2];
                if (bytes_left != 0) begin
                    if (!nibble_waiting) begin
                        held_nibble    = gray;
                        nibble_waiting = 1'b1;
                    end else begin
                        nibble_waiting = 1'b0;
                        bytes_left     = bytes_left - 1'b1;
                        push_byte({held_nibble, gray}, 1'b1, 1'b1, bytes_left == 0);
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic compare_byte(input t_result got);
        t_result want;
        if (expected_bytes.size() == 0) begin
            $error("out_byte: no byte expected, got %02h", got.out_byte);
            mismatches++;
        end else begin
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
                mismatches++;
            end
            if (got.is_data !== want.is_data) begin
                $error("is_data: expected %0b, got %0b", want.is_data, got.is_data);
                mismatches++;
            end
            if (got.run_last !== want.run_last) begin
                $error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
                mismatches++;
            end
            if (got.region_done !== want.region_done) begin
                $error("region_done: expected %0b, got %0b", want.region_done,
                       got.region_done);
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            panel_cfg = '{column_offset: 7'd28, oscillator_setting: 8'd145,
                          mux_ratio: 7'd63, segment_current: 8'd255, master_current: 4'd15,
                          precharge_voltage: 5'd31, precharge_period: 4'd8};
            held_nibble    = '0;
            nibble_waiting = 1'b0;
            bytes_left     = '0;
            expected_bytes.delete();
            mismatches     = 0;
        end else begin
            if (i_result_valid && i_result_ready) begin
                compare_byte(i_result_payload);
            end
            if (i_item_valid && i_item_ready) begin
                predict_bytes(i_item_payload);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_COLUMN_OFFSET:      panel_cfg.column_offset      = i_cfg_data[6:0];
                    CFG_OSCILLATOR_SETTING: panel_cfg.oscillator_setting = i_cfg_data;
                    CFG_MUX_RATIO:          panel_cfg.mux_ratio          = i_cfg_data[6:0];
                    CFG_SEGMENT_CURRENT:    panel_cfg.segment_current    = i_cfg_data;
                    CFG_MASTER_CURRENT:     panel_cfg.master_current     = i_cfg_data[3:0];
                    CFG_PRECHARGE_VOLTAGE:  panel_cfg.precharge_voltage  = i_cfg_data[4:0];
                    CFG_PRECHARGE_PERIOD:   panel_cfg.precharge_period   = i_cfg_data[3:0];
                    default: begin
                    end
                endcase
            end
        end
        o_fail_count  <= mismatches;
        o_outstanding <= expected_bytes.size();
    end

endmodule

>>> tb/sv/grayscale_oled_region_writer_core_test.sv
// Testbench top that drives items, registers and back-pressure and reports the verdict.
`timescale 1ns / 100ps
module grayscale_oled_region_writer_core_test;
    import orw_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_ITEMS  = 380;
    localparam int PHASES        = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;
    localparam logic [1:0]           KIND_UNUSED      = 2'd3;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    int fail_count;
    int outstanding;
    int cycle_count    = 0;
    int sender_idle    = 0;
    int receiver_stall = 0;

    orw_stream_if #(.t_payload(t_item))   item_ch ();
    orw_stream_if #(.t_payload(t_result)) result_ch ();

    grayscale_oled_region_writer_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_ch),
        .o_result    (result_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    grayscale_oled_region_writer_core_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item_valid     (item_ch.valid),
        .i_item_ready     (item_ch.ready),
        .i_item_payload   (item_ch.payload),
        .i_result_valid   (result_ch.valid),
        .i_result_ready   (result_ch.ready),
        .i_result_payload (result_ch.payload),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_outstanding    (outstanding)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count     <= cycle_count + 1;
        result_ch.ready <= ($urandom_range(0, 99) >= receiver_stall);
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    function automatic t_item make_item(input logic [1:0] kind);
        t_item it;
        it.kind    = kind;
        it.x_first = 8'($urandom);
        it.x_last  = 8'($urandom);
        it.y_first = 7'($urandom);
        it.y_last  = 7'($urandom);
        it.green   = 6'($urandom);
        return it;
    endfunction

    function automatic t_item region_item(input logic [7:0] x1, input logic [7:0] x2,
                                          input logic [6:0] y1, input logic [6:0] y2);
        t_item it;
        it         = make_item(KIND_REGION);
        it.x_first = x1;
        it.x_last  = x2;
        it.y_first = y1;
        it.y_last  = y2;
        return it;
    endfunction

    function automatic logic [7:0] setting_value(input int phase);
        case (phase)
            0:       return 8'hff;
            1:       return 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_item(input t_item it);
        while ($urandom_range(0, 99) < sender_idle) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.payload <= it;
        @(posedge i_clk);
        while (!item_ch.ready) begin
            @(posedge i_clk);
        end
    endtask

    // Held pixels and dropped items cause no byte, so the task waits out a settle period after the last one.
    task automatic wait_for_drain();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index, input logic [7:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    initial begin
        t_item      it;
        logic [5:0] directed_greens [8];
        int         phase;
        int         counted;
        int         pick;
        int         span;
        int         rows;
        int         xs;
        int         ys;
        int         pixels;
        item_ch.valid   = 1'b0;
        item_ch.payload = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the register defaults.
        send_item(make_item(KIND_INIT));
        send_item(make_item(KIND_PIXEL));
        send_item(region_item(8'd0, 8'd255, 7'd0, 7'd127));
        it = make_item(KIND_PIXEL);
        it.green = 6'h3f;
        send_item(it);
        it.green = 6'h00;
        send_item(it);
        send_item(region_item(8'h03, 8'h04, 7'd5, 7'd5));
        directed_greens = '{6'h3f, 6'h00, 6'h03, 6'h3c, 6'h2a, 6'h15, 6'h01, 6'h3e};
        for (int i = 0; i < 8; i++) begin
            it.green = directed_greens[i];
            send_item(it);
        end
        send_item(make_item(KIND_PIXEL));
        send_item(region_item(8'hfc, 8'hf8, 7'd0, 7'd127));
        send_item(region_item(8'd0, 8'd255, 7'd127, 7'd0));
        send_item(make_item(KIND_UNUSED));
        send_item(region_item(8'h10, 8'h1f, 7'd2, 7'd3));
        send_item(make_item(KIND_PIXEL));
        send_item(region_item(8'h40, 8'h43, 7'd126, 7'd127));
        send_item(make_item(KIND_PIXEL));
        send_item(make_item(KIND_INIT));
        send_item(make_item(KIND_PIXEL));

        for (phase = 0; phase < PHASES; phase++) begin
            wait_for_drain();
            write_register(CFG_COLUMN_OFFSET, setting_value(phase));
            write_register(CFG_OSCILLATOR_SETTING, setting_value(phase));
            write_register(CFG_MUX_RATIO, setting_value(phase));
            write_register(CFG_SEGMENT_CURRENT, setting_value(phase));
            write_register(CFG_MASTER_CURRENT, setting_value(phase));
            write_register(CFG_PRECHARGE_VOLTAGE, setting_value(phase));
            write_register(CFG_PRECHARGE_PERIOD, setting_value(phase));
            write_register(CFG_UNUSED_INDEX, setting_value(phase));
            i_cfg_we <= 1'b0;
            case (phase)
                0:       begin sender_idle = 0;  receiver_stall = 0;  end
                1:       begin sender_idle = 78; receiver_stall = 0;  end
                2:       begin sender_idle = 0;  receiver_stall = 78; end
                default: begin sender_idle = 10; receiver_stall = 10; end
            endcase
            counted = 0;
            while (counted < RANDOM_ITEMS / PHASES) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    // A well-formed region followed by its pixel stream, sometimes cut short or run over.
                    span = $urandom_range(1, 4);
                    rows = $urandom_range(1, 3);
                    xs   = 4 * $urandom_range(0, 64 - span);
                    ys   = $urandom_range(0, 128 - rows);
                    send_item(region_item(8'(xs + $urandom_range(0, 3)),
                                          8'(xs + 4 * span - 4 + $urandom_range(0, 3)),
                                          7'(ys), 7'(ys + rows - 1)));
                    pixels = 4 * span * rows;
                    if ($urandom_range(0, 9) == 0) begin
                        pixels = $urandom_range(0, pixels - 1);
                    end
                    counted += pixels + 1;
                    if ($urandom_range(0, 4) == 0) begin
                        pixels += $urandom_range(1, 2);
                    end
                    repeat (pixels) send_item(make_item(KIND_PIXEL));
                end else if (pick < 80) begin
                    // A random region followed by only one to six pixels.
                    it = make_item(KIND_REGION);
                    it.x_last = 8'($urandom_range(it.x_first, 255));
                    it.y_last = 7'($urandom_range(it.y_first, 127));
                    send_item(it);
                    pixels = $urandom_range(1, 6);
                    repeat (pixels) send_item(make_item(KIND_PIXEL));
                    counted += pixels + 1;
                end else if (pick < 88) begin
                    send_item(make_item(2'($urandom_range(0, 3))));
                end else begin
                    send_item(make_item(KIND_INIT));
                    counted++;
                end
            end
        end

        wait_for_drain();
        if (fail_count == 0 && outstanding == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/orw_pkg.sv
rtl/orw_stream_if.sv
rtl/orw_queue.sv
rtl/orw_front.sv
rtl/orw_back.sv
rtl/grayscale_oled_region_writer_core.sv
tb/sv/grayscale_oled_region_writer_core_checker.sv
tb/sv/grayscale_oled_region_writer_core_test.sv
